// ===== src/knps_pkg.sv =====
`timescale 1ns / 1ps
// knps_pkg: shared constants, register indexes and controller/datapath types
// for the nearest point selector. No dependencies.
package knps_pkg;

   localparam int MAX_NEIGHBOURS_DEF = 8;
   localparam int COORD_BITS         = 16;
   localparam int SQUARE_BITS        = 2 * COORD_BITS;
   localparam int DIST_BITS          = 2 * COORD_BITS + 1;
   localparam int COUNT_BITS         = 4;

   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 16;
   localparam int REQ_DATA_BITS      = 2 * COORD_BITS;
   localparam int RSP_DATA_BITS      = ((2 * COORD_BITS + DIST_BITS + 7) / 8) * 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_X         = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_Y         = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOUR_COUNT = 2'd2;

   localparam logic [COUNT_BITS-1:0] NEIGHBOUR_COUNT_RESET = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic square_en;
      logic insert_en;
      logic load_out;
      logic out_last;
      logic clear_fill;
   } cmd_type;

   typedef struct packed {
      logic set_end;
      logic out_free;
   } status_type;

endpackage

// ===== src/k_nearest_point_select_core.sv =====
`timescale 1ns / 1ps
// Each point is captured with its coordinate differences from the query,
// then squared by the two squaring multipliers, then its distance is added
// and the point is put into the sorted list by a parallel compare-and-shift
// insert. The point that carries tlast then gives one result per cycle (at
// most neighbour_count, capped at MAX_NEIGHBOURS) while rsp_tready allows,
// or only clears the list if there are none. A new point is taken while the
// last result still waits in the output register.
// Depends on knps_pkg, knps_ctrl and knps_datapath.
module k_nearest_point_select_core #(
   parameter int MAX_NEIGHBOURS = knps_pkg::MAX_NEIGHBOURS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [knps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [knps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [knps_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // point_x, point_y
   input  logic                                req_tlast,  // set_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // near_x, near_y, dist_squared, zero pad
   output logic [knps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast   // final_result
);

   localparam int FILL_W = $clog2(MAX_NEIGHBOURS + 1);
   localparam int IDX_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   knps_pkg::cmd_type    cmd;
   knps_pkg::status_type status;
   logic [FILL_W-1:0]    emit_total;
   logic [FILL_W-1:0]    fill;
   logic [IDX_W-1:0]     emit_idx;

   knps_ctrl #(
      .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
      .FILL_W        (FILL_W),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .emit_total(emit_total),
      .cmd       (cmd),
      .emit_idx  (emit_idx)
   );

   knps_datapath #(
      .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
      .FILL_W        (FILL_W),
      .IDX_W         (IDX_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .emit_idx  (emit_idx),
      .status    (status),
      .emit_total(emit_total),
      .fill      (fill),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= FILL_W'(MAX_NEIGHBOURS))
      else $error("neighbour list fill exceeds its depth");

   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && cmd.out_last |=> fill == '0)
      else $error("list not cleared after final result");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (FILL_W'(emit_idx) < emit_total) && (emit_total <= fill))
      else $error("result read beyond held entries");

   a_no_load_while_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result register overwritten before transfer");

endmodule

// ===== src/knps_datapath.sv =====
`timescale 1ns / 1ps
// knps_datapath: configuration registers, distance pipeline, sorted neighbour
// list and result register. Depends on knps_pkg; driven by knps_ctrl commands.
module knps_datapath #(
   parameter int MAX_NEIGHBOURS = knps_pkg::MAX_NEIGHBOURS_DEF,
   parameter int FILL_W         = $clog2(MAX_NEIGHBOURS + 1),
   parameter int IDX_W          = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [knps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [knps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [knps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   input  knps_pkg::cmd_type                   cmd,
   input  logic [IDX_W-1:0]                    emit_idx,
   output knps_pkg::status_type                status,
   output logic [FILL_W-1:0]                   emit_total,
   output logic [FILL_W-1:0]                   fill,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [knps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CW    = knps_pkg::COORD_BITS;
   localparam int DW    = knps_pkg::DIST_BITS;
   localparam int SW    = knps_pkg::SQUARE_BITS;
   localparam int CMP_W = (FILL_W > knps_pkg::COUNT_BITS) ? FILL_W : knps_pkg::COUNT_BITS;
   localparam int PAD_W = knps_pkg::RSP_DATA_BITS - 2 * CW - DW;

   logic [CW-1:0]                   query_x_ff, query_y_ff;
   logic [knps_pkg::COUNT_BITS-1:0] ncount_ff;
   logic [CW-1:0]                   px_ff, py_ff, dx_ff, dy_ff;
   logic [CW-1:0]                   px_in, py_in, dx_in, dy_in;
   logic                            last_ff;
   logic [SW-1:0]                   sqx_ff, sqy_ff;
   logic [DW-1:0]                   dist_sq;
   logic [FILL_W-1:0]               fill_ff;

   logic [CW-1:0] list_x_ff [MAX_NEIGHBOURS];
   logic [CW-1:0] list_y_ff [MAX_NEIGHBOURS];
   logic [DW-1:0] list_d_ff [MAX_NEIGHBOURS];
   logic [CW-1:0] list_x_in [MAX_NEIGHBOURS];
   logic [CW-1:0] list_y_in [MAX_NEIGHBOURS];
   logic [DW-1:0] list_d_in [MAX_NEIGHBOURS];
   logic [CW-1:0] prev_x    [MAX_NEIGHBOURS];
   logic [CW-1:0] prev_y    [MAX_NEIGHBOURS];
   logic [DW-1:0] prev_d    [MAX_NEIGHBOURS];

   logic [MAX_NEIGHBOURS-1:0] le, take_prev, take_new;
   logic                      insert_go;

   logic              rsp_valid_ff, rsp_last_ff;
   logic [CW-1:0]     rsp_x_ff, rsp_y_ff;
   logic [DW-1:0]     rsp_d_ff;
   logic [CMP_W-1:0]  want, fill_ext;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
         ncount_ff  <= knps_pkg::NEIGHBOUR_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            knps_pkg::CSR_QUERY_X:         query_x_ff <= csr_wdata[CW-1:0];
            knps_pkg::CSR_QUERY_Y:         query_y_ff <= csr_wdata[CW-1:0];
            knps_pkg::CSR_NEIGHBOUR_COUNT: ncount_ff  <= csr_wdata[knps_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // capture point and absolute differences
   always_comb begin
      px_in = req_tdata[CW-1:0];
      py_in = req_tdata[2*CW-1:CW];
      dx_in = (px_in >= query_x_ff) ? px_in - query_x_ff : query_x_ff - px_in;
      dy_in = (py_in >= query_y_ff) ? py_in - query_y_ff : query_y_ff - py_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         last_ff <= req_tlast;
      end
      if (cmd.square_en) begin
         sqx_ff <= SW'(dx_ff) * SW'(dx_ff);
         sqy_ff <= SW'(dy_ff) * SW'(dy_ff);
      end
   end

   assign dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // sorted insertion: le marks the prefix of held entries at or below dist_sq
   always_comb begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         le[i] = (FILL_W'(i) < fill_ff) && (list_d_ff[i] <= dist_sq);
      end
   end

   for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign take_prev[g] = 1'b0;
         assign take_new[g]  = ~le[g];
         assign prev_x[g]    = px_ff;
         assign prev_y[g]    = py_ff;
         assign prev_d[g]    = dist_sq;
      end else begin : g_body
         assign take_prev[g] = ~le[g-1];
         assign take_new[g]  = le[g-1] & ~le[g];
         assign prev_x[g]    = list_x_ff[g-1];
         assign prev_y[g]    = list_y_ff[g-1];
         assign prev_d[g]    = list_d_ff[g-1];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         list_x_in[i] = list_x_ff[i];
         list_y_in[i] = list_y_ff[i];
         list_d_in[i] = list_d_ff[i];
         if (take_prev[i]) begin
            list_x_in[i] = prev_x[i];
            list_y_in[i] = prev_y[i];
            list_d_in[i] = prev_d[i];
         end else if (take_new[i]) begin
            list_x_in[i] = px_ff;
            list_y_in[i] = py_ff;
            list_d_in[i] = dist_sq;
         end
      end
   end

   // drop the query itself and anything not nearer than a full list's tail
   assign insert_go = cmd.insert_en && (dist_sq != '0) && !le[MAX_NEIGHBOURS-1];

   always_ff @(posedge clock) begin
      if (insert_go) begin
         for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
            list_x_ff[i] <= list_x_in[i];
            list_y_ff[i] <= list_y_in[i];
            list_d_ff[i] <= list_d_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.clear_fill) begin
         fill_ff <= '0;
      end else if (insert_go && (fill_ff < FILL_W'(MAX_NEIGHBOURS))) begin
         fill_ff <= fill_ff + FILL_W'(1);
      end
   end

   // results to give: min(fill, saturated neighbour count)
   always_comb begin
      want       = (CMP_W'(ncount_ff) > CMP_W'(MAX_NEIGHBOURS)) ?
                   CMP_W'(MAX_NEIGHBOURS) : CMP_W'(ncount_ff);
      fill_ext   = CMP_W'(fill_ff);
      emit_total = (fill_ext < want) ? fill_ff : FILL_W'(want);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_x_ff    <= list_x_ff[emit_idx];
         rsp_y_ff    <= list_y_ff[emit_idx];
         rsp_d_ff    <= list_d_ff[emit_idx];
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign status.set_end  = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign fill            = fill_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tlast       = rsp_last_ff;
   assign rsp_tdata       = {{PAD_W{1'b0}}, rsp_d_ff, rsp_y_ff, rsp_x_ff};

endmodule

// ===== src/knps_ctrl.sv =====
`timescale 1ns / 1ps
// knps_ctrl: sequencer for the nearest point selector: capture, square,
// insert, then result readout at set end. Depends on knps_pkg.
module knps_ctrl #(
   parameter int MAX_NEIGHBOURS = knps_pkg::MAX_NEIGHBOURS_DEF,
   parameter int FILL_W         = $clog2(MAX_NEIGHBOURS + 1),
   parameter int IDX_W          = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  knps_pkg::status_type status,
   input  logic [FILL_W-1:0]    emit_total,
   output knps_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     emit_idx
);

   knps_pkg::state_type state_ff, state_in;
   logic [FILL_W-1:0]   emit_cnt_ff, emit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= knps_pkg::ST_IDLE;
         emit_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      emit_cnt_in = emit_cnt_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         knps_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            emit_cnt_in = '0;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = knps_pkg::ST_SQUARE;
            end
         end
         knps_pkg::ST_SQUARE: begin
            cmd.square_en = 1'b1;
            state_in      = knps_pkg::ST_INSERT;
         end
         knps_pkg::ST_INSERT: begin
            cmd.insert_en = 1'b1;
            state_in      = status.set_end ? knps_pkg::ST_EMIT : knps_pkg::ST_IDLE;
         end
         knps_pkg::ST_EMIT: begin
            if (emit_total == '0) begin
               cmd.clear_fill = 1'b1;
               state_in       = knps_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = (emit_cnt_ff + FILL_W'(1)) == emit_total;
               if (cmd.out_last) begin
                  // list is read into the result register on this same edge
                  cmd.clear_fill = 1'b1;
                  state_in       = knps_pkg::ST_IDLE;
               end else begin
                  emit_cnt_in = emit_cnt_ff + FILL_W'(1);
               end
            end
         end
         default: state_in = knps_pkg::ST_IDLE;
      endcase
   end

   assign emit_idx = emit_cnt_ff[IDX_W-1:0];

endmodule

// ===== sim/tb_k_nearest_point_select_core.sv =====
`timescale 1ns / 1ps
// tb_k_nearest_point_select_core: self-checking testbench for the nearest point
// selector. A scoreboard class keeps its own sorted list per point set.
// Depends on knps_pkg and k_nearest_point_select_core.
module tb_k_nearest_point_select_core;

   localparam int MAX_N         = knps_pkg::MAX_NEIGHBOURS_DEF;
   localparam int CW            = knps_pkg::COORD_BITS;
   localparam int DW            = knps_pkg::DIST_BITS;
   localparam int NW            = knps_pkg::COUNT_BITS;
   localparam int IW            = knps_pkg::CSR_INDEX_BITS;
   localparam int VW            = knps_pkg::CSR_DATA_BITS;
   localparam int RW            = knps_pkg::RSP_DATA_BITS;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 270;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [CW-1:0] COORD_MAX = '1;

   typedef logic [CW-1:0] coord_type;
   typedef logic [DW:0]   wide_dist_type;

   typedef struct packed {
      coord_type    x;
      coord_type    y;
      logic [DW-1:0] dist_sq;
      logic          last;
   } neighbour_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_TOGGLE
   } ready_mode_type;

   class neighbour_scoreboard;
      coord_type       query_x;
      coord_type       query_y;
      logic [NW-1:0]   neighbour_count;
      coord_type       list_x [MAX_N];
      coord_type       list_y [MAX_N];
      wide_dist_type   list_dist [MAX_N];
      int              list_fill;
      neighbour_type   pending_neighbours [$];
      int              errors;

      function new();
         query_x         = '0;
         query_y         = '0;
         neighbour_count = knps_pkg::NEIGHBOUR_COUNT_RESET;
         list_fill       = 0;
         errors          = 0;
      endfunction

      function void set_register(logic [IW-1:0] index, logic [VW-1:0] value);
         case (index)
            knps_pkg::CSR_QUERY_X: query_x = value[CW-1:0];
            knps_pkg::CSR_QUERY_Y: query_y = value[CW-1:0];
            knps_pkg::CSR_NEIGHBOUR_COUNT: neighbour_count = value[NW-1:0];
            default: ;
         endcase
      endfunction

      // Insert behind all entries of equal distance; the farthest falls off when full.
      function void rank_point(coord_type px, coord_type py, wide_dist_type dsq);
         int pos;
         int top;
         int k;
         pos = list_fill;
         while (pos > 0 && list_dist[pos-1] > dsq) pos--;
         if (pos >= MAX_N) return;
         top = (list_fill < MAX_N) ? list_fill : MAX_N - 1;
         for (k = top; k > pos; k--) begin
            list_x[k]    = list_x[k-1];
            list_y[k]    = list_y[k-1];
            list_dist[k] = list_dist[k-1];
         end
         list_x[pos]    = px;
         list_y[pos]    = py;
         list_dist[pos] = dsq;
         if (list_fill < MAX_N) list_fill++;
      endfunction

      function void note_point(coord_type px, coord_type py, logic set_end);
         wide_dist_type dx;
         wide_dist_type dy;
         wide_dist_type dsq;
         int            limit;
         int            n;
         int            k;
         neighbour_type nb;
         dx   = (px >= query_x) ? (DW+1)'(px - query_x) : (DW+1)'(query_x - px);
         dy   = (py >= query_y) ? (DW+1)'(py - query_y) : (DW+1)'(query_y - py);
         dsq  = dx * dx + dy * dy;
         if (dsq != 0) rank_point(px, py, dsq);
         if (!set_end) return;
         limit = (neighbour_count > MAX_N) ? MAX_N : int'(neighbour_count);
         n     = (list_fill < limit) ? list_fill : limit;
         for (k = 0; k < n; k++) begin
            nb.x       = list_x[k];
            nb.y       = list_y[k];
            nb.dist_sq = list_dist[k][DW-1:0];
            nb.last    = (k == n - 1);
            pending_neighbours = {pending_neighbours, nb};
         end
         list_fill = 0;
      endfunction

      function int pending();
         return pending_neighbours.size();
      endfunction

      function void check_neighbour(logic [RW-1:0] data, logic last);
         neighbour_type got;
         neighbour_type exp_nb;
         got.x       = data[CW-1:0];
         got.y       = data[2*CW-1:CW];
         got.dist_sq = data[2*CW +: DW];
         got.last    = last;
         if (pending_neighbours.size() == 0) begin
            errors++;
            $display("%0t: unexpected neighbour, expected none, actual x=%0d y=%0d d=%0d last=%0b",
                     $time, got.x, got.y, got.dist_sq, got.last);
            return;
         end
         exp_nb = pending_neighbours.pop_front();
         if (got.x !== exp_nb.x) begin
            errors++;
            $display("%0t: near_x expected %0d actual %0d", $time, exp_nb.x, got.x);
         end
         if (got.y !== exp_nb.y) begin
            errors++;
            $display("%0t: near_y expected %0d actual %0d", $time, exp_nb.y, got.y);
         end
         if (got.dist_sq !== exp_nb.dist_sq) begin
            errors++;
            $display("%0t: dist_squared expected %0d actual %0d", $time, exp_nb.dist_sq,
                     got.dist_sq);
         end
         if (got.last !== exp_nb.last) begin
            errors++;
            $display("%0t: final_result expected %0b actual %0b", $time, exp_nb.last, got.last);
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en = 1'b0;
   logic [IW-1:0]                       csr_index = '0;
   logic [VW-1:0]                       csr_wdata = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [knps_pkg::REQ_DATA_BITS-1:0]  req_tdata = '0;   // point_x, point_y
   logic                                req_tlast = 1'b0; // set_end
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [RW-1:0]                       rsp_tdata;        // near_x, near_y, dist_squared, pad
   logic                                rsp_tlast;        // final_result

   neighbour_scoreboard board;
   int             sent_items   = 0;
   int             burst_left   = 0;
   bit             hold_request = 1'b0;
   int             hold_left    = 0;
   int             pattern_left = 0;
   ready_mode_type ready_mode   = READY_ALWAYS;

   k_nearest_point_select_core #(
      .MAX_NEIGHBOURS(MAX_N)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Receiver: pick a new random ready pattern each time the current one runs out; a hold request blocks it.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (pattern_left == 0) begin
         ready_mode   = ready_mode_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(10, 60);
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_tready = 1'b1;
            READY_HALF:   rsp_tready = 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready = ($urandom_range(0, 3) == 0);
            default:      rsp_tready = ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_neighbour(rsp_tdata, rsp_tlast);
   end

   task automatic write_register(input logic [IW-1:0] index, input logic [VW-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      board.set_register(index, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_point(input coord_type px, input coord_type py, input logic set_end);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {py, px};
      req_tlast  = set_end;
      do @(posedge clock); while (!req_tready);
      board.note_point(px, py, set_end);
      sent_items++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid, wait for every expected neighbour, then let the pipeline empty.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
         end
         if (gap > 0) idle_sender(gap);
      end
      burst_left--;
   endtask

   function automatic coord_type near_coord(input coord_type centre, input int spread);
      int r;
      int v;
      r = $urandom_range(0, 2 * spread);
      v = int'(centre) + r - spread;
      if (v < 0) v = 0;
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      return coord_type'(v);
   endfunction

   function automatic coord_type pick_query();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return COORD_MAX;
         default: return coord_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic configure_phase();
      logic [VW-1:0] count;
      if ($urandom_range(0, 2) != 0) begin
         write_register(knps_pkg::CSR_QUERY_X, pick_query());
         write_register(knps_pkg::CSR_QUERY_Y, pick_query());
      end
      if ($urandom_range(0, 3) == 0) count = VW'($urandom_range(0, 15));
      else count = VW'($urandom_range(1, 8));
      write_register(knps_pkg::CSR_NEIGHBOUR_COUNT, count);
   endtask

   task automatic send_random_set();
      int        length;
      coord_type px;
      coord_type py;
      px = coord_type'($urandom_range(0, 65535));
      py = coord_type'($urandom_range(0, 65535));
      length = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
      for (int i = 0; i < length; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               px = board.query_x;
               py = board.query_y;
            end
            1: ;  // repeat the previous point for an equal distance
            2, 3, 4, 5: begin
               px = near_coord(board.query_x, 16);
               py = near_coord(board.query_y, 16);
            end
            6: begin
               px = near_coord(board.query_x, 3000);
               py = near_coord(board.query_y, 3000);
            end
            default: begin
               px = coord_type'($urandom_range(0, 65535));
               py = coord_type'($urandom_range(0, 65535));
            end
         endcase
         pace();
         send_point(px, py, i == length - 1);
      end
   endtask

   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int directed_items;
      int phase;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Query itself on an empty list, then the farthest point alone.
      send_point(16'd0, 16'd0, 1'b1);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      // Equal distances keep arrival order; the query point is skipped.
      send_point(16'd3, 16'd4, 1'b0);
      send_point(16'd4, 16'd3, 1'b0);
      send_point(16'd1, 16'd1, 1'b0);
      send_point(16'd0, 16'd0, 1'b0);
      send_point(16'd5, 16'd0, 1'b0);
      send_point(16'd2, 16'd0, 1'b1);
      wait_idle();

      // Fill the list past capacity while the receiver is held off.
      write_register(knps_pkg::CSR_QUERY_X, COORD_MAX);
      write_register(knps_pkg::CSR_QUERY_Y, COORD_MAX);
      write_register(knps_pkg::CSR_NEIGHBOUR_COUNT, 16'd8);
      hold_request = 1'b1;
      for (int i = 0; i < 10; i++)
         send_point(COORD_MAX - coord_type'((i * 7) % 10 + 1), COORD_MAX, 1'b0);
      // Equal to the last entry: dropped.
      send_point(COORD_MAX, COORD_MAX - 16'd8, 1'b1);
      send_point(16'd0, 16'd0, 1'b0);
      send_point(COORD_MAX, 16'd0, 1'b0);
      send_point(16'd0, COORD_MAX, 1'b1);
      wait_idle();

      // Count zero still clears the list; count fifteen saturates.
      write_register(knps_pkg::CSR_NEIGHBOUR_COUNT, 16'd0);
      send_point(16'd10, 16'd10, 1'b0);
      send_point(16'd20, 16'd20, 1'b1);
      wait_idle();
      write_register(knps_pkg::CSR_NEIGHBOUR_COUNT, 16'd15);
      send_point(16'd1, 16'd2, 1'b1);

      directed_items = sent_items;
      phase = 0;
      while (sent_items < directed_items + RANDOM_ITEMS) begin
         wait_idle();
         configure_phase();
         if (phase == 3) hold_request = 1'b1;
         repeat ($urandom_range(1, 4)) send_random_set();
         phase++;
      end

      wait_idle();
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
